// ----- hw/rtl/dqfa_pkg.sv -----
`timescale 1ns / 1ps
// dqfa_pkg: shared types, constants and byte tables for the DNS fixed-answer responder.
// No dependencies; used by every module of the block.
package dqfa_pkg;

    // Datagram limits
    localparam int MAX_LEN = 496;
    localparam int HDR_LEN = 12;
    localparam int POS_W   = $clog2(MAX_LEN + 1);
    // Label pointer can reach the last position plus a full label
    localparam int LBL_W   = $clog2(MAX_LEN + 256 + 1);
    // Offset from the zero label to just past QCLASS
    localparam int QTAIL   = 5;

    // Appended A record length in bytes
    localparam int REC_LEN  = 16;
    localparam int STEP_W   = $clog2(REC_LEN + 1);
    localparam int REC_IX_W = $clog2(REC_LEN);

    // Command queue depth between front and back
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // Configuration register indexes
    localparam logic [1:0] REG_ENABLE  = 2'd0;
    localparam logic [1:0] REG_ADDRESS = 2'd1;
    localparam logic [1:0] REG_TTL     = 2'd2;

    localparam logic [31:0] ADDRESS_RST = 32'hC0A8_0401;
    localparam logic [31:0] TTL_RST     = 32'd30;

    // Command kinds
    localparam logic [1:0] KIND_PLAIN  = 2'd0;
    localparam logic [1:0] KIND_ABORT  = 2'd1;
    localparam logic [1:0] KIND_APPEND = 2'd2;

    typedef struct packed {
        logic [1:0] kind;
        logic       have;
        logic [7:0] data;
    } cmd_t;

    // Rewritten header byte at position p (p below HDR_LEN)
    function automatic logic [7:0] header_byte(input logic [3:0] p, input logic [7:0] b);
        logic [7:0] r;
        r = b;
        case (p)
            4'd2:  r = 8'h84;
            4'd7:  r = 8'h01;
            4'd3, 4'd6, 4'd8, 4'd9, 4'd10, 4'd11: r = 8'h00;
            default: r = b;
        endcase
        return r;
    endfunction

    // Byte idx of the appended A record
    function automatic logic [7:0] record_byte(input logic [REC_IX_W-1:0] idx,
                                               input logic [31:0] ttl,
                                               input logic [31:0] addr);
        logic [7:0] r;
        r = 8'h00;
        unique case (idx)
            4'd0:  r = 8'hC0;
            4'd1:  r = 8'h0C;
            4'd2:  r = 8'h00;
            4'd3:  r = 8'h01;
            4'd4:  r = 8'h00;
            4'd5:  r = 8'h01;
            4'd6:  r = ttl[31:24];
            4'd7:  r = ttl[23:16];
            4'd8:  r = ttl[15:8];
            4'd9:  r = ttl[7:0];
            4'd10: r = 8'h00;
            4'd11: r = 8'h04;
            4'd12: r = addr[31:24];
            4'd13: r = addr[23:16];
            4'd14: r = addr[15:8];
            4'd15: r = addr[7:0];
        endcase
        return r;
    endfunction

endpackage

// ----- hw/rtl/dqfa_front.sv -----
`timescale 1ns / 1ps
// dqfa_front: takes query bytes, walks the question name and issues commands.
// Depends on dqfa_pkg.
module dqfa_front
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             enable,
    input  logic             in_xfer,
    input  logic [7:0]       in_byte,
    input  logic             in_last,
    output logic             push,
    output dqfa_pkg::cmd_t   cmd
);

    logic [dqfa_pkg::POS_W-1:0] pos_reg,   pos_next;
    logic [dqfa_pkg::LBL_W-1:0] label_reg, label_next;
    logic [dqfa_pkg::LBL_W-1:0] qend_reg,  qend_next;
    logic                       done_reg,  done_next;

    logic                       pos_ok;
    logic                       have;
    logic [7:0]                 ob;
    logic [dqfa_pkg::LBL_W-1:0] p_ext;
    logic [dqfa_pkg::POS_W-1:0] len;
    logic                       bad;

    // Per-byte classification and name walk
    always_comb
    begin
        pos_next   = pos_reg;
        label_next = label_reg;
        qend_next  = qend_reg;
        done_next  = done_reg;
        have       = 1'b0;
        ob         = in_byte;
        push       = 1'b0;
        cmd        = '0;
        p_ext      = dqfa_pkg::LBL_W'(pos_reg);
        pos_ok     = (pos_reg < dqfa_pkg::POS_W'(dqfa_pkg::MAX_LEN));
        len        = pos_reg;
        bad        = 1'b0;

        if (pos_ok)
        begin
            if (pos_reg < dqfa_pkg::POS_W'(dqfa_pkg::HDR_LEN))
            begin
                ob   = dqfa_pkg::header_byte(pos_reg[3:0], in_byte);
                have = 1'b1;
            end
            else if (!done_reg)
            begin
                if (p_ext == label_reg)
                begin
                    if (in_byte == 8'h00)
                    begin
                        qend_next = p_ext + dqfa_pkg::LBL_W'(dqfa_pkg::QTAIL);
                        done_next = 1'b1;
                    end
                    else
                    begin
                        label_next = p_ext + dqfa_pkg::LBL_W'(in_byte) + 1'b1;
                    end
                end
                have = 1'b1;
            end
            else if (p_ext < qend_reg)
            begin
                have = 1'b1;
            end
            pos_next = pos_reg + 1'b1;
            len      = pos_reg + 1'b1;
        end

        bad = (len < dqfa_pkg::POS_W'(dqfa_pkg::HDR_LEN)) || !done_next ||
              (qend_next > dqfa_pkg::LBL_W'(len));

        cmd.data = ob;
        cmd.have = have;
        cmd.kind = dqfa_pkg::KIND_PLAIN;

        if (in_last)
        begin
            push = in_xfer && enable;
            if (bad)
            begin
                cmd.kind = dqfa_pkg::KIND_ABORT;
                cmd.data = 8'h00;
            end
            else
            begin
                cmd.kind = dqfa_pkg::KIND_APPEND;
            end
        end
        else
        begin
            push = in_xfer && enable && have;
        end

        // End of datagram or disabled: back to reset state
        if (in_last || !enable)
        begin
            pos_next   = '0;
            label_next = dqfa_pkg::LBL_W'(dqfa_pkg::HDR_LEN);
            qend_next  = '0;
            done_next  = 1'b0;
        end
    end

    // Walk state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            label_reg <= dqfa_pkg::LBL_W'(dqfa_pkg::HDR_LEN);
            qend_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else if (in_xfer)
        begin
            pos_reg   <= pos_next;
            label_reg <= label_next;
            qend_reg  <= qend_next;
            done_reg  <= done_next;
        end
    end

    // Position saturates at the truncation limit
    a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= dqfa_pkg::POS_W'(dqfa_pkg::MAX_LEN))
        else $error("byte position beyond truncation limit");

    // Every last byte taken while enabled leaves a command
    a_last_push: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer && enable && in_last |-> push)
        else $error("last byte produced no command");

endmodule

// ----- hw/rtl/dqfa_queue.sv -----
`timescale 1ns / 1ps
// dqfa_queue: short command queue between the front and the back.
// Depends on dqfa_pkg.
module dqfa_queue
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  dqfa_pkg::cmd_t  push_cmd,
    output logic            full,
    input  logic            pop,
    output logic            head_valid,
    output dqfa_pkg::cmd_t  head
);

    dqfa_pkg::cmd_t              mem_reg [dqfa_pkg::QDEPTH];
    logic [dqfa_pkg::QPTR_W-1:0] wr_reg, wr_next;
    logic [dqfa_pkg::QPTR_W-1:0] rd_reg, rd_next;
    logic [dqfa_pkg::QCNT_W-1:0] cnt_reg, cnt_next;

    assign full       = (cnt_reg == dqfa_pkg::QCNT_W'(dqfa_pkg::QDEPTH));
    assign head_valid = (cnt_reg != '0);
    assign head       = mem_reg[rd_reg];

    // Pointer and fill count update
    always_comb
    begin
        wr_next  = wr_reg;
        rd_next  = rd_reg;
        cnt_next = cnt_reg;
        if (push)
        begin
            wr_next = (wr_reg == dqfa_pkg::QPTR_W'(dqfa_pkg::QDEPTH - 1)) ? '0 : wr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_next = (rd_reg == dqfa_pkg::QPTR_W'(dqfa_pkg::QDEPTH - 1)) ? '0 : rd_reg + 1'b1;
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_reg] <= push_cmd;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !push)
        else $error("command pushed into full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !head_valid |-> !pop)
        else $error("command popped from empty queue");

endmodule

// ----- hw/rtl/dqfa_back.sv -----
`timescale 1ns / 1ps
// dqfa_back: carries out queued commands into the reply stream, appending the A record.
// Depends on dqfa_pkg.
module dqfa_back
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic [31:0]     answer_address,
    input  logic [31:0]     answer_ttl,
    input  logic            head_valid,
    input  dqfa_pkg::cmd_t  head,
    output logic            pop,
    output logic            out_valid,
    input  logic            out_ready,
    output logic [7:0]      out_byte,
    output logic            out_last,
    output logic            out_abort
);

    logic [dqfa_pkg::STEP_W-1:0]   step_reg, step_next;
    logic [dqfa_pkg::STEP_W-1:0]   eff_step;
    logic [dqfa_pkg::REC_IX_W-1:0] rec_ix;
    logic                          valid_reg, valid_next;
    logic [7:0]                    byte_reg, byte_next;
    logic                          last_reg, last_next;
    logic                          abort_reg, abort_next;
    logic                          load;
    logic                          final_step;

    // Step 0 is the carried byte, steps 1..REC_LEN the record
    always_comb
    begin
        eff_step = step_reg;
        if (step_reg == '0 && !head.have)
        begin
            eff_step = dqfa_pkg::STEP_W'(1);
        end
        rec_ix     = dqfa_pkg::REC_IX_W'(eff_step - 1'b1);
        final_step = (head.kind != dqfa_pkg::KIND_APPEND) ||
                     (eff_step == dqfa_pkg::STEP_W'(dqfa_pkg::REC_LEN));
        load       = head_valid && (!valid_reg || out_ready);
        pop        = load && final_step;

        byte_next  = byte_reg;
        last_next  = last_reg;
        abort_next = abort_reg;
        step_next  = step_reg;
        valid_next = valid_reg && !out_ready;

        if (load)
        begin
            valid_next = 1'b1;
            step_next  = final_step ? '0 : eff_step + 1'b1;
            abort_next = (head.kind == dqfa_pkg::KIND_ABORT);
            last_next  = (head.kind == dqfa_pkg::KIND_ABORT) ||
                         ((head.kind == dqfa_pkg::KIND_APPEND) && final_step);
            byte_next  = head.data;
            if (head.kind == dqfa_pkg::KIND_ABORT)
            begin
                byte_next = 8'h00;
            end
            else if (head.kind == dqfa_pkg::KIND_APPEND && eff_step != '0)
            begin
                byte_next = dqfa_pkg::record_byte(rec_ix, answer_ttl, answer_address);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            step_reg  <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            step_reg  <= step_next;
        end
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        byte_reg  <= byte_next;
        last_reg  <= last_next;
        abort_reg <= abort_next;
    end

    assign out_valid = valid_reg;
    assign out_byte  = byte_reg;
    assign out_last  = last_reg;
    assign out_abort = abort_reg;

    a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
        step_reg <= dqfa_pkg::STEP_W'(dqfa_pkg::REC_LEN))
        else $error("record step out of range");

    a_abort_last: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && abort_reg |-> last_reg && byte_reg == 8'h00)
        else $error("abort not on a final zero byte");

endmodule

// ----- hw/rtl/dns_query_to_fixed_answer.sv -----
`timescale 1ns / 1ps
// Path: a kept query byte is stored in the command queue, then in the output register.
// Throughput: one byte per cycle in and out while the command queue is not full and
// the reply side is ready; the final query byte of a good query expands into up to 17
// output bytes (16 when that byte itself is dropped), input keeps flowing until the
// four-entry command queue fills. Set by the single output register of the back end.
// Reset: configuration returns to defaults (disabled, 192.168.4.1, TTL 30), queue empty.
module dns_query_to_fixed_answer
(
    input  logic        clk,
    input  logic        rst_n,
    // configuration write port
    input  logic        cfg_wen,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_wdata,
    // query stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
    input  logic        s_axis_tlast,
    // reply stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] out_byte
    output logic        m_axis_tlast,
    output logic        m_axis_tuser    // [0] abort
);

    logic            enable_reg;
    logic [31:0]     address_reg;
    logic [31:0]     ttl_reg;

    logic            q_full;
    logic            in_xfer;
    logic            push;
    dqfa_pkg::cmd_t  push_cmd;
    logic            pop;
    logic            head_valid;
    dqfa_pkg::cmd_t  head;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg  <= 1'b0;
            address_reg <= dqfa_pkg::ADDRESS_RST;
            ttl_reg     <= dqfa_pkg::TTL_RST;
        end
        else if (cfg_wen)
        begin
            unique case (cfg_index)
                dqfa_pkg::REG_ENABLE:  enable_reg  <= cfg_wdata[0];
                dqfa_pkg::REG_ADDRESS: address_reg <= cfg_wdata;
                dqfa_pkg::REG_TTL:     ttl_reg     <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign s_axis_tready = !q_full;
    assign in_xfer       = s_axis_tvalid && s_axis_tready;

    dqfa_front u_front
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .enable  (enable_reg),
        .in_xfer (in_xfer),
        .in_byte (s_axis_tdata),
        .in_last (s_axis_tlast),
        .push    (push),
        .cmd     (push_cmd)
    );

    dqfa_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_cmd   (push_cmd),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head       (head)
    );

    dqfa_back u_back
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .answer_address (address_reg),
        .answer_ttl     (ttl_reg),
        .head_valid     (head_valid),
        .head           (head),
        .pop            (pop),
        .out_valid      (m_axis_tvalid),
        .out_ready      (m_axis_tready),
        .out_byte       (m_axis_tdata),
        .out_last       (m_axis_tlast),
        .out_abort      (m_axis_tuser)
    );

endmodule

// ----- verif/tb_dns_query_to_fixed_answer.sv -----
`timescale 1ns / 1ps
// tb_dns_query_to_fixed_answer: self-checking bench for the DNS fixed-answer responder.
// Drives query datagrams byte by byte, predicts every reply byte and compares them in order.
// Depends on dqfa_pkg and dns_query_to_fixed_answer only.
module tb_dns_query_to_fixed_answer;

    // Reply field values used by the predictor
    localparam logic [7:0]  FLAGS_REPLY  = 8'h84;   // QR=1, AA=1
    localparam logic [7:0]  ANCOUNT_LOW  = 8'h01;
    localparam logic [15:0] NAME_PTR     = 16'hC00C;
    localparam logic [15:0] TYPE_A       = 16'h0001;
    localparam logic [15:0] CLASS_IN     = 16'h0001;
    localparam logic [15:0] RDLENGTH_V4  = 16'h0004;
    // Index outside the register map, writes must be dropped
    localparam logic [1:0]  REG_SPARE    = 2'd3;

    localparam int LONG_HOLD    = 300;
    localparam int ROUNDS       = 8;
    localparam int ROUND_ITEMS  = 56;
    localparam int SETTLE       = 8;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       abort;
    } reply_t;

    // Tracks the responder's per-datagram walk and holds the reply bytes still due
    class reply_tracker_t;
        logic        enable;
        logic [31:0] address;
        logic [31:0] ttl;
        int unsigned position;
        int unsigned next_label;
        int unsigned question_end;
        bit          name_done;
        reply_t      reply_bytes_due[$];
        int          errors;

        function new();
            enable  = 1'b0;
            address = dqfa_pkg::ADDRESS_RST;
            ttl     = dqfa_pkg::TTL_RST;
            errors  = 0;
            restart();
        endfunction

        function void restart();
            position     = 0;
            next_label   = dqfa_pkg::HDR_LEN;
            question_end = 0;
            name_done    = 1'b0;
        endfunction

        function void note_config(logic [1:0] idx, logic [31:0] value);
            case (idx)
                dqfa_pkg::REG_ENABLE:  enable  = value[0];
                dqfa_pkg::REG_ADDRESS: address = value;
                dqfa_pkg::REG_TTL:     ttl     = value;
                default: ;
            endcase
        endfunction

        function int pending();
            return reply_bytes_due.size();
        endfunction

        function void due(logic [7:0] d, logic l, logic a);
            reply_t r;
            r.data  = d;
            r.last  = l;
            r.abort = a;
            reply_bytes_due.push_back(r);
        endfunction

        // Header rewrite: flags, zeroed counts, single answer
        function logic [7:0] rewrite_header(int unsigned p, logic [7:0] b);
            case (p)
                2:                     return FLAGS_REPLY;
                7:                     return ANCOUNT_LOW;
                3, 6, 8, 9, 10, 11:    return 8'h00;
                default:               return b;
            endcase
        endfunction

        function void note_query_byte(logic [7:0] b, logic last);
            logic [7:0] rec [dqfa_pkg::REC_LEN];
            logic [7:0] ob;
            bit         have;
            int         i;
            have = 1'b0;
            ob   = 8'h00;
            if (!enable)
            begin
                restart();
                return;
            end
            // bytes past the receive limit are ignored, their end mark is not
            if (position < dqfa_pkg::MAX_LEN)
            begin
                if (position < dqfa_pkg::HDR_LEN)
                begin
                    ob   = rewrite_header(position, b);
                    have = 1'b1;
                end
                else if (!name_done)
                begin
                    if (position == next_label)
                    begin
                        if (b == 8'h00)
                        begin
                            question_end = position + dqfa_pkg::QTAIL;
                            name_done    = 1'b1;
                        end
                        else
                            next_label = position + b + 1;
                    end
                    ob   = b;
                    have = 1'b1;
                end
                else if (position < question_end)
                begin
                    ob   = b;
                    have = 1'b1;
                end
                position = position + 1;
            end
            if (!last)
            begin
                if (have)
                    due(ob, 1'b0, 1'b0);
                return;
            end
            // short datagram or question running past the end
            if (position < dqfa_pkg::HDR_LEN || !name_done || question_end > position)
            begin
                restart();
                due(8'h00, 1'b1, 1'b1);
                return;
            end
            if (have)
                due(ob, 1'b0, 1'b0);
            rec = '{NAME_PTR[15:8], NAME_PTR[7:0], TYPE_A[15:8], TYPE_A[7:0],
                    CLASS_IN[15:8], CLASS_IN[7:0], ttl[31:24], ttl[23:16], ttl[15:8], ttl[7:0],
                    RDLENGTH_V4[15:8], RDLENGTH_V4[7:0],
                    address[31:24], address[23:16], address[15:8], address[7:0]};
            for (i = 0; i < dqfa_pkg::REC_LEN; i++)
                due(rec[i], i == dqfa_pkg::REC_LEN - 1, 1'b0);
            restart();
        endfunction

        function void check_result(logic [7:0] d, logic l, logic a);
            reply_t want;
            if (reply_bytes_due.size() == 0)
            begin
                $error("reply transfer with nothing due: out_byte %02h last %0b abort %0b",
                       d, l, a);
                errors++;
                return;
            end
            want = reply_bytes_due.pop_front();
            if (d !== want.data)
            begin
                $error("out_byte: expected %02h, got %02h", want.data, d);
                errors++;
            end
            if (l !== want.last)
            begin
                $error("out_last: expected %0b, got %0b", want.last, l);
                errors++;
            end
            if (a !== want.abort)
            begin
                $error("abort: expected %0b, got %0b", want.abort, a);
                errors++;
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_wen;
    logic [1:0]  cfg_index;
    logic [31:0] cfg_wdata;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;      // [7:0] in_byte
    logic        s_axis_tlast;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;      // [7:0] out_byte
    logic        m_axis_tlast;
    logic        m_axis_tuser;      // [0] abort

    reply_tracker_t reply_log;
    logic [7:0]     query[$];
    int             idle_pct;
    int             stall_pct;
    int             hold_req;
    int             hold_seen = 0;
    int             hold_left = 0;

    dns_query_to_fixed_answer dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wen       (cfg_wen),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    // 20 ns clock
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Reply side: random stalls, plus a long hold-off on request
    always @(posedge clk)
    begin
        if (hold_seen != hold_req)
        begin
            hold_seen = hold_req;
            hold_left = LONG_HOLD;
        end
        if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
    end

    // Query transfers feed the predictor
    always @(posedge clk)
        if (rst_n && s_axis_tvalid && s_axis_tready)
            reply_log.note_query_byte(s_axis_tdata, s_axis_tlast);

    // Reply transfers are checked in order
    always @(posedge clk)
        if (rst_n && m_axis_tvalid && m_axis_tready)
            reply_log.check_result(m_axis_tdata, m_axis_tlast, m_axis_tuser);

    // Run limit
    initial
    begin
        #20ms;
        $display("CHECKS FAILED");
        $finish;
    end

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        @(posedge clk);
        cfg_wen   <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        reply_log.note_config(idx, value);
        @(posedge clk);
        cfg_wen   <= 1'b0;
    endtask

    // Offer one byte, with random gaps, and wait for its transfer
    task automatic send_byte(input logic [7:0] b, input logic last);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= last;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
    endtask

    task automatic send_query();
        int i;
        for (i = 0; i < query.size(); i++)
            send_byte(query[i], i == query.size() - 1);
    endtask

    // Stop offering and let every due reply byte come out
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        // the final transfer is noted by the predictor at the edge just passed
        @(posedge clk);
        while (reply_log.pending() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic set_traffic(input int phase);
        case (phase)
            1:       begin idle_pct = 60; stall_pct <= 0;  end
            2:       begin idle_pct = 0;  stall_pct <= 60; end
            3:       begin idle_pct = 19; stall_pct <= 19; end
            default: begin idle_pct = 0;  stall_pct <= 0;  end
        endcase
    endtask

    function automatic logic [7:0] rand_byte();
        return 8'($urandom_range(0, 255));
    endfunction

    // Mostly well-formed queries; some short, noisy or cut short
    task automatic build_query();
        int shape;
        int len;
        int cut;
        query.delete();
        shape = $urandom_range(0, 99);
        if (shape < 8)
        begin
            len = $urandom_range(1, dqfa_pkg::HDR_LEN - 1);
            repeat (len) query.push_back(rand_byte());
            return;
        end
        repeat (dqfa_pkg::HDR_LEN) query.push_back(rand_byte());
        if (shape < 15)
        begin
            // random bytes where the name should be
            repeat ($urandom_range(1, 30)) query.push_back(rand_byte());
            return;
        end
        repeat ($urandom_range(0, 3))
        begin
            len = ($urandom_range(0, 9) == 0) ? 63 : $urandom_range(1, 10);
            query.push_back(8'(len));
            repeat (len) query.push_back(rand_byte());
        end
        query.push_back(8'h00);
        if ($urandom_range(0, 3) == 0)
            repeat (4) query.push_back(rand_byte());
        else
        begin
            query.push_back(TYPE_A[15:8]);
            query.push_back(TYPE_A[7:0]);
            query.push_back(CLASS_IN[15:8]);
            query.push_back(CLASS_IN[7:0]);
        end
        // trailing records, dropped by the block
        if ($urandom_range(0, 2) == 0)
            repeat ($urandom_range(1, 12)) query.push_back(rand_byte());
        if (shape < 25)
        begin
            cut = $urandom_range(dqfa_pkg::HDR_LEN, query.size() - 1);
            while (query.size() > cut)
                void'(query.pop_back());
        end
    endtask

    // Datagrams running past the receive limit
    task automatic build_long(input bit good);
        int target;
        query.delete();
        target = dqfa_pkg::MAX_LEN + $urandom_range(1, 14);
        repeat (dqfa_pkg::HDR_LEN) query.push_back(rand_byte());
        if (good)
        begin
            query.push_back(8'd3);
            repeat (3) query.push_back(rand_byte());
            query.push_back(8'h00);
            repeat (4) query.push_back(rand_byte());
            while (query.size() < target)
                query.push_back(rand_byte());
        end
        else
            // labels that never end within the limit
            while (query.size() < target)
            begin
                query.push_back(8'd63);
                repeat (63) query.push_back(rand_byte());
            end
    endtask

    initial
    begin
        int round;
        int round_items;
        int i;
        reply_log     = new();
        rst_n         = 1'b0;
        cfg_wen       = 1'b0;
        cfg_index     = dqfa_pkg::REG_ENABLE;
        cfg_wdata     = 32'd0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = 8'h00;
        s_axis_tlast  = 1'b0;
        idle_pct      = 0;
        stall_pct     = 0;
        hold_req      = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Disabled after reset: bytes are swallowed
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hA5, 1'b1);
        wait_drained();
        write_reg(REG_SPARE, 32'hFFFF_FFFF);
        write_reg(dqfa_pkg::REG_ENABLE, 32'd1);

        // Minimal query with alternating header extremes
        query.delete();
        for (i = 0; i < dqfa_pkg::HDR_LEN; i++)
            query.push_back(i[0] ? 8'hFF : 8'h00);
        query.push_back(8'h00);
        query.push_back(8'hFF);
        query.push_back(8'hFF);
        query.push_back(8'h00);
        query.push_back(8'hFF);
        send_query();
        // one-byte datagram
        send_byte(8'hFF, 1'b1);
        wait_drained();

        for (round = 0; round < ROUNDS; round++)
        begin
            wait_drained();
            case (round)
                0:
                begin
                    write_reg(dqfa_pkg::REG_ADDRESS, 32'h0000_0000);
                    write_reg(dqfa_pkg::REG_TTL, 32'h0000_0000);
                end
                1:
                begin
                    write_reg(dqfa_pkg::REG_ADDRESS, 32'hFFFF_FFFF);
                    write_reg(dqfa_pkg::REG_TTL, 32'hFFFF_FFFF);
                end
                3:
                begin
                    // a datagram offered while disabled leaves no trace
                    write_reg(dqfa_pkg::REG_ENABLE, 32'd0);
                    set_traffic(0);
                    build_query();
                    send_query();
                    wait_drained();
                    write_reg(dqfa_pkg::REG_ENABLE, 32'd1);
                    write_reg(dqfa_pkg::REG_TTL, $urandom());
                end
                7:
                begin
                    write_reg(dqfa_pkg::REG_ADDRESS, $urandom());
                    write_reg(REG_SPARE, $urandom());
                end
                default:
                begin
                    write_reg(dqfa_pkg::REG_ADDRESS, $urandom());
                    write_reg(dqfa_pkg::REG_TTL, $urandom());
                end
            endcase

            set_traffic(round % 4);
            if (round == 2)
                hold_req <= hold_req + 1;
            if (round == 4 || round == 5)
            begin
                build_long(round == 4);
                send_query();
            end

            round_items = 0;
            while (round_items < ROUND_ITEMS)
            begin
                set_traffic(($urandom_range(0, 3) == 0) ? 0 : round % 4);
                build_query();
                send_query();
                round_items += query.size();
            end
        end

        wait_drained();
        repeat (20) @(posedge clk);
        if (reply_log.errors == 0 && reply_log.pending() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ----- files.f -----
hw/rtl/dqfa_pkg.sv
hw/rtl/dqfa_front.sv
hw/rtl/dqfa_queue.sv
hw/rtl/dqfa_back.sv
hw/rtl/dns_query_to_fixed_answer.sv
verif/tb_dns_query_to_fixed_answer.sv
